>>> sv/kpt_pkg.sv
// Shared types and codes of the k-mer presence table.
`timescale 1ns / 1ps

package kpt_pkg;

    localparam int KEY_W  = 62;
    localparam int PRES_W = 32;

    // remainder unit: bits retired per step and steps per 64-bit dividend
    localparam int MOD_DIGITS = 8;
    localparam int MOD_STEPS  = 64 / MOD_DIGITS;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [2:0] ST_NEW       = 3'd0;
    localparam logic [2:0] ST_FWD_HIT   = 3'd1;
    localparam logic [2:0] ST_REV_HIT   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_READ_OK   = 3'd4;
    localparam logic [2:0] ST_READ_NONE = 3'd5;
    localparam logic [2:0] ST_CLEARED   = 3'd6;

    typedef struct packed {
        logic [1:0]       mode;
        logic [KEY_W-1:0] kmer_value;
        logic [KEY_W-1:0] rc_value;
        logic [4:0]       species;
        logic [9:0]       bucket;
        logic [1:0]       slot;
    } t_in_req;

    typedef struct packed {
        logic [2:0]        status;
        logic [KEY_W-1:0]  entry_key;
        logic [PRES_W-1:0] presence;
    } t_out_rsp;

endpackage

>>> sv/kmer_presence_table_core.sv
// K-mer presence table: bucketed hash table with a sequenced single-port scan.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_ready   i_in  (kpt_pkg::t_in_req)
// response  out        o_out_valid / i_out_ready o_out (kpt_pkg::t_out_rsp)
//
// One request at a time; o_in_ready is high only while the sequencer is idle.
// Insert: per bucket, remainder unit (one step when BUCKETS is a power of two,
//   else 8 steps), fill read and check, a read and a compare per filled slot;
//   one or two buckets, then append and post; a hit stops at its compare and
//   posts next. The single entry-memory port gives each slot a read and a
//   compare state. Read: fill read, check, entry read (none for an empty slot).
//   Clear: sweeps all buckets. After reset the fill-count memory is swept to
//   zero, o_in_ready low. A full response register stalls only the posting step.

module kmer_presence_table_core #(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4,
    parameter int SPECIES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  kpt_pkg::t_in_req  i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output kpt_pkg::t_out_rsp o_out
);
    import kpt_pkg::*;

    localparam int  BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int  FW    = $clog2(WAYS + 1);
    localparam int  DEPTH = BUCKETS * WAYS;
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam bit  POW2  = ((1 << BW) == BUCKETS);
    localparam logic [BW:0]   BUCKETS_R = (BW + 1)'(BUCKETS);
    localparam logic [BW-1:0] LAST_BKT  = BW'(BUCKETS - 1);
    localparam logic [2:0]    MOD_LAST  = 3'(MOD_STEPS - 1);

    typedef enum logic [11:0] {
        S_INIT     = 12'b000000000001,
        S_IDLE     = 12'b000000000010,
        S_MOD      = 12'b000000000100,
        S_FILL_RD  = 12'b000000001000,
        S_FILL_CHK = 12'b000000010000,
        S_SCAN_RD  = 12'b000000100000,
        S_SCAN_CMP = 12'b000001000000,
        S_APPEND   = 12'b000010000000,
        S_RD_FILL  = 12'b000100000000,
        S_RD_CHK   = 12'b001000000000,
        S_RD_ENT   = 12'b010000000000,
        S_CLEAR    = 12'b100000000000
    } t_state;

    // response is posted from the idle-bound path; track it separately
    logic r_post, n_post;

    t_state r_state, n_state;
    logic [BW-1:0]  r_sweep, n_sweep;
    t_in_req        r_req, n_req;
    logic           r_rev, n_rev;
    logic [BW-1:0]  r_bkt, n_bkt;
    logic [BW-1:0]  r_fwd_bkt, n_fwd_bkt;
    logic [FW-1:0]  r_fwd_fill, n_fwd_fill;
    logic [FW-1:0]  r_slot, n_slot;
    logic [63:0]    r_div, n_div;
    logic [BW-1:0]  r_rem, n_rem;
    logic [2:0]     r_mcnt, n_mcnt;
    t_out_rsp       r_rsp, n_rsp;
    logic           r_out_valid, n_out_valid;
    t_out_rsp       r_out, n_out;

    // memories
    logic [FW-1:0]      fill_mem [BUCKETS];
    logic [KEY_W-1:0]   key_mem  [DEPTH];
    logic [SPECIES-1:0] pres_mem [DEPTH];
    logic [FW-1:0]      r_fill_q;
    logic [KEY_W-1:0]   r_key_q;
    logic [SPECIES-1:0] r_pres_q;

    logic               fill_rd_en, fill_we;
    logic [BW-1:0]      fill_addr;
    logic [FW-1:0]      fill_wd;
    logic               ent_rd_en, ent_we;
    logic [AW-1:0]      ent_addr;
    logic [BW-1:0]      ent_bkt;
    logic [FW-1:0]      ent_slot;
    logic [KEY_W-1:0]   ent_wkey;
    logic [SPECIES-1:0] ent_wpres;

    logic [BW-1:0]      mod_rem;
    logic [SPECIES-1:0] sp_bit;
    logic [SPECIES-1:0] hit_pres;
    logic [KEY_W-1:0]   want_key;
    logic               out_free;

    assign o_in_ready  = (r_state == S_IDLE) && !r_post;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign out_free    = !r_out_valid || i_out_ready;

    // remainder unit: retire MOD_DIGITS dividend bits per step
    always_comb begin
        logic [BW:0]   t;
        logic [BW-1:0] acc;
        acc = r_rem;
        for (int j = 0; j < MOD_DIGITS; j++) begin
            t = {acc, r_div[63-j]};
            if (t >= BUCKETS_R) begin
                t = t - BUCKETS_R;
            end
            acc = t[BW-1:0];
        end
        mod_rem = acc;
    end

    assign sp_bit   = (32'(r_req.species) < SPECIES) ?
                      (SPECIES'(1) << r_req.species) : '0;
    assign hit_pres = r_pres_q | sp_bit;
    assign want_key = r_rev ? r_req.rc_value : r_req.kmer_value;

    assign ent_bkt  = (r_state == S_APPEND) ? r_fwd_bkt  : r_bkt;
    assign ent_slot = (r_state == S_APPEND) ? r_fwd_fill : r_slot;
    assign ent_addr = AW'(ent_bkt) * AW'(WAYS) + AW'(ent_slot);

    always_comb begin
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_req       = r_req;
        n_rev       = r_rev;
        n_bkt       = r_bkt;
        n_fwd_bkt   = r_fwd_bkt;
        n_fwd_fill  = r_fwd_fill;
        n_slot      = r_slot;
        n_div       = r_div;
        n_rem       = r_rem;
        n_mcnt      = r_mcnt;
        n_rsp       = r_rsp;
        n_post      = r_post;
        fill_rd_en  = 1'b0;
        fill_we     = 1'b0;
        fill_addr   = r_bkt;
        fill_wd     = '0;
        ent_rd_en   = 1'b0;
        ent_we      = 1'b0;
        ent_wkey    = r_key_q;
        ent_wpres   = hit_pres;

        unique case (r_state)
            S_INIT: begin
                // zero every fill count after reset
                fill_we   = 1'b1;
                fill_addr = r_sweep;
                n_sweep   = r_sweep + 1'b1;
                if (r_sweep == LAST_BKT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_req  = i_in;
                    n_rev  = 1'b0;
                    n_slot = FW'(i_in.slot);
                    n_bkt  = BW'(i_in.bucket);
                    unique case (i_in.mode)
                        MODE_INSERT: begin
                            n_div   = 64'(i_in.kmer_value);
                            n_rem   = '0;
                            n_mcnt  = '0;
                            n_state = S_MOD;
                        end
                        MODE_READ: begin
                            if ((32'(i_in.bucket) < BUCKETS) && (32'(i_in.slot) < WAYS)) begin
                                n_state = S_RD_FILL;
                            end else begin
                                n_rsp  = '{status: ST_READ_NONE, entry_key: '0, presence: '0};
                                n_post = 1'b1;
                            end
                        end
                        MODE_CLEAR: begin
                            n_sweep = '0;
                            n_state = S_CLEAR;
                        end
                        default: begin
                            // unused mode: drop without a response
                        end
                    endcase
                end
            end
            S_MOD: begin
                n_div  = r_div << MOD_DIGITS;
                n_rem  = mod_rem;
                n_mcnt = r_mcnt + 1'b1;
                if (POW2) begin
                    n_bkt   = r_div[BW-1:0];
                    n_state = S_FILL_RD;
                end else if (r_mcnt == MOD_LAST) begin
                    n_bkt   = mod_rem;
                    n_state = S_FILL_RD;
                end
            end
            S_FILL_RD: begin
                fill_rd_en = 1'b1;
                n_state    = S_FILL_CHK;
            end
            S_FILL_CHK: begin
                if (!r_rev) begin
                    n_fwd_bkt  = r_bkt;
                    n_fwd_fill = r_fill_q;
                end
                n_slot  = '0;
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                if (r_slot < r_fill_q) begin
                    ent_rd_en = 1'b1;
                    n_state   = S_SCAN_CMP;
                end else if (!r_rev) begin
                    // forward miss: hash the reverse complement next
                    n_rev   = 1'b1;
                    n_div   = 64'(r_req.rc_value);
                    n_rem   = '0;
                    n_mcnt  = '0;
                    n_state = S_MOD;
                end else begin
                    n_state = S_APPEND;
                end
            end
            S_SCAN_CMP: begin
                if (r_key_q == want_key) begin
                    ent_we  = 1'b1;
                    n_rsp   = '{status: (r_rev ? ST_REV_HIT : ST_FWD_HIT),
                                entry_key: r_key_q, presence: PRES_W'(hit_pres)};
                    n_post  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_slot  = r_slot + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_APPEND: begin
                if (r_fwd_fill >= FW'(WAYS)) begin
                    n_rsp = '{status: ST_FULL, entry_key: r_req.kmer_value, presence: '0};
                end else begin
                    ent_we    = 1'b1;
                    ent_wkey  = r_req.kmer_value;
                    ent_wpres = sp_bit;
                    fill_we   = 1'b1;
                    fill_addr = r_fwd_bkt;
                    fill_wd   = r_fwd_fill + 1'b1;
                    n_rsp     = '{status: ST_NEW, entry_key: r_req.kmer_value,
                                  presence: PRES_W'(sp_bit)};
                end
                n_post  = 1'b1;
                n_state = S_IDLE;
            end
            S_RD_FILL: begin
                fill_rd_en = 1'b1;
                n_state    = S_RD_CHK;
            end
            S_RD_CHK: begin
                if (r_slot < r_fill_q) begin
                    ent_rd_en = 1'b1;
                    n_state   = S_RD_ENT;
                end else begin
                    n_rsp   = '{status: ST_READ_NONE, entry_key: '0, presence: '0};
                    n_post  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RD_ENT: begin
                n_rsp   = '{status: ST_READ_OK, entry_key: r_key_q,
                            presence: PRES_W'(r_pres_q)};
                n_post  = 1'b1;
                n_state = S_IDLE;
            end
            S_CLEAR: begin
                fill_we   = 1'b1;
                fill_addr = r_sweep;
                n_sweep   = r_sweep + 1'b1;
                if (r_sweep == LAST_BKT) begin
                    n_rsp   = '{status: ST_CLEARED, entry_key: '0, presence: '0};
                    n_post  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // hand a finished response to the output register once it frees up
        if (r_post && out_free) begin
            n_post = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_post && out_free) begin
            n_out_valid = 1'b1;
            n_out       = r_rsp;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_post      <= 1'b0;
            r_out_valid <= 1'b0;
            r_rev       <= 1'b0;
            r_mcnt      <= '0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_post      <= n_post;
            r_out_valid <= n_out_valid;
            r_rev       <= n_rev;
            r_mcnt      <= n_mcnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_bkt      <= n_bkt;
        r_fwd_bkt  <= n_fwd_bkt;
        r_fwd_fill <= n_fwd_fill;
        r_slot     <= n_slot;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_rsp      <= n_rsp;
        r_out      <= n_out;
    end

    // fill-count memory, one port
    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            fill_mem[fill_addr] <= fill_wd;
        end
        if (fill_rd_en) begin
            r_fill_q <= fill_mem[fill_addr];
        end
    end

    // entry memory, one port shared by scan, update and append
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            key_mem[ent_addr]  <= ent_wkey;
            pres_mem[ent_addr] <= ent_wpres;
        end
        if (ent_rd_en) begin
            r_key_q  <= key_mem[ent_addr];
            r_pres_q <= pres_mem[ent_addr];
        end
    end

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the k-mer presence table core.
`timescale 1ns / 1ps

module tb_top;
    import kpt_pkg::*;

    // Table geometry of the instance under test (the core's defaults)
    localparam int NUM_BKT    = 1024;
    localparam int NUM_WAYS   = 4;
    localparam int NUM_SPEC   = 32;
    // Run length guard and quiet tail after the last response
    localparam int CYCLE_LIMIT = 800000;
    localparam int TAIL_CYCLES = 1100;
    // Length of the long receiver hold-off, and random items per phase
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 462;
    localparam int HOT_N       = 8;

    // One request waiting to be offered, with the flow control it runs under
    typedef struct {
        t_in_req     req;
        int unsigned send_idle_pct;
        int unsigned recv_stall_pct;
        bit          drain_first;
        bit          hold_rx;
    } t_pending;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_req   i_in        = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_rsp  o_out;

    // Shadow copy of the table used to predict responses
    int unsigned     fill_shadow [NUM_BKT];
    logic [KEY_W-1:0]  key_shadow  [NUM_BKT*NUM_WAYS];
    logic [PRES_W-1:0] pres_shadow [NUM_BKT*NUM_WAYS];

    t_pending  req_backlog_q[$];
    t_out_rsp  rsp_due_q[$];

    int unsigned n_launched   = 0;
    int unsigned n_accepted   = 0;
    int unsigned err_cnt      = 0;
    int unsigned cycle_cnt    = 0;
    int unsigned hold_req_cnt = 0;
    int unsigned hold_seen    = 0;
    int unsigned hold_left    = 0;
    int unsigned stall_pct    = 0;

    kmer_presence_table_core #(
        .BUCKETS (NUM_BKT),
        .WAYS    (NUM_WAYS),
        .SPECIES (NUM_SPEC)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Table prediction
    // ------------------------------------------------------------------

    // Return the flat entry index of key in bucket b, or -1 on a miss.
    function automatic int find_entry(input int unsigned b, input logic [KEY_W-1:0] key);
        int unsigned n;
        n = (fill_shadow[b] > NUM_WAYS) ? NUM_WAYS : fill_shadow[b];
        for (int unsigned i = 0; i < n; i++) begin
            if (key_shadow[b*NUM_WAYS + i] == key) return int'(b*NUM_WAYS + i);
        end
        return -1;
    endfunction

    // Apply one request to the shadow table; return 1 when it yields a response.
    function automatic bit table_apply(input t_in_req r, output t_out_rsp rsp);
        int unsigned       fb;
        int unsigned       e_idx;
        int                hit;
        logic [PRES_W-1:0] bit_mask;
        rsp = '0;
        case (r.mode)
            MODE_INSERT: begin
                fb       = int'(r.kmer_value[9:0]);
                bit_mask = (int'(r.species) < NUM_SPEC) ? (PRES_W'(1) << r.species) : '0;
                hit = find_entry(fb, r.kmer_value);
                rsp.status = ST_FWD_HIT;
                if (hit < 0) begin
                    // forward miss: look for the reverse complement in its own bucket
                    hit = find_entry(int'(r.rc_value[9:0]), r.rc_value);
                    rsp.status = ST_REV_HIT;
                end
                if (hit < 0) begin
                    if (fill_shadow[fb] >= NUM_WAYS) begin
                        // full bucket: drop the k-mer, table unchanged
                        rsp.status    = ST_FULL;
                        rsp.entry_key = r.kmer_value;
                        rsp.presence  = '0;
                        return 1'b1;
                    end
                    hit = int'(fb*NUM_WAYS + fill_shadow[fb]);
                    key_shadow[hit]  = r.kmer_value;
                    pres_shadow[hit] = '0;
                    fill_shadow[fb]++;
                    rsp.status = ST_NEW;
                end
                e_idx = hit;
                pres_shadow[e_idx] |= bit_mask;
                rsp.entry_key = key_shadow[e_idx];
                rsp.presence  = pres_shadow[e_idx];
                return 1'b1;
            end
            MODE_READ: begin
                if (int'(r.slot) < NUM_WAYS && int'(r.slot) < fill_shadow[r.bucket]) begin
                    e_idx = int'(r.bucket)*NUM_WAYS + int'(r.slot);
                    rsp.status    = ST_READ_OK;
                    rsp.entry_key = key_shadow[e_idx];
                    rsp.presence  = pres_shadow[e_idx];
                end else begin
                    rsp.status = ST_READ_NONE;
                end
                return 1'b1;
            end
            MODE_CLEAR: begin
                for (int i = 0; i < NUM_BKT; i++) fill_shadow[i] = 0;
                rsp.status = ST_CLEARED;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [KEY_W-1:0] rand_key();
        return KEY_W'({$urandom(), $urandom()});
    endfunction

    // Reverse complement of a 31-base k-mer: reverse the bases, complement each.
    function automatic logic [KEY_W-1:0] rev_comp(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] rc;
        for (int i = 0; i < KEY_W/2; i++) rc[2*(KEY_W/2-1-i) +: 2] = ~k[2*i +: 2];
        return rc;
    endfunction

    function automatic t_in_req make_req(input logic [1:0] mode, input logic [KEY_W-1:0] key,
                                         input logic [KEY_W-1:0] rc, input logic [4:0] sp,
                                         input logic [9:0] bkt, input logic [1:0] slt);
        t_in_req r;
        r.mode       = mode;
        r.kmer_value = key;
        r.rc_value   = rc;
        r.species    = sp;
        r.bucket     = bkt;
        r.slot       = slt;
        return r;
    endfunction

    function automatic void push_item(input t_in_req r, input int unsigned idle_pct,
                                      input int unsigned rstall_pct, input bit drain,
                                      input bit hold);
        t_pending p;
        p.req            = r;
        p.send_idle_pct  = idle_pct;
        p.recv_stall_pct = rstall_pct;
        p.drain_first    = drain;
        p.hold_rx        = hold;
        req_backlog_q.insert(req_backlog_q.size(), p);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: drive at the falling edge from the backlog
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : req_driver
        t_pending nxt;
        logic     nv;
        nv = i_in_valid;
        if (i_rst_n) begin
            // drop valid once the current request went through
            if (nv && n_launched == n_accepted) nv = 1'b0;
            if (!nv && req_backlog_q.size() != 0) begin
                nxt = req_backlog_q[0];
                // hold a drain request until every response is back
                if (!(nxt.drain_first && rsp_due_q.size() != 0) &&
                    $urandom_range(0, 99) >= nxt.send_idle_pct) begin
                    void'(req_backlog_q.pop_front());
                    i_in       <= nxt.req;
                    nv          = 1'b1;
                    n_launched++;
                    stall_pct  <= nxt.recv_stall_pct;
                    if (nxt.hold_rx) hold_req_cnt <= hold_req_cnt + 1;
                end
            end
        end
        i_in_valid <= nv;
    end

    // ------------------------------------------------------------------
    // Response receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : rsp_receiver
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (hold_seen != hold_req_cnt) begin
                hold_seen = hold_req_cnt;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge, predict, compare
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : handshake_monitor
        t_out_rsp want;
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                n_accepted++;
                if (table_apply(i_in, want)) rsp_due_q.insert(rsp_due_q.size(), want);
            end
            if (o_out_valid && i_out_ready) begin
                if (rsp_due_q.size() == 0) begin
                    $error("unexpected response: status %0d key %h presence %h",
                           o_out.status, o_out.entry_key, o_out.presence);
                    err_cnt++;
                end else begin
                    want = rsp_due_q.pop_front();
                    if (o_out.status !== want.status) begin
                        $error("status mismatch: expected %0d actual %0d",
                               want.status, o_out.status);
                        err_cnt++;
                    end
                    if (o_out.entry_key !== want.entry_key) begin
                        $error("entry_key mismatch: expected %h actual %h",
                               want.entry_key, o_out.entry_key);
                        err_cnt++;
                    end
                    if (o_out.presence !== want.presence) begin
                        $error("presence mismatch: expected %h actual %h",
                               want.presence, o_out.presence);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : test_seq
        t_in_req          r;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] rc;
        logic [KEY_W-1:0] seen_keys[$];
        logic [9:0]       hot_bkt[HOT_N];
        int unsigned      send_pct[4];
        int unsigned      recv_pct[4];
        int unsigned      roll;
        int unsigned      sub;
        int unsigned      count;
        bit               first;

        for (int i = 0; i < NUM_BKT; i++) fill_shadow[i] = 0;
        for (int i = 0; i < NUM_BKT*NUM_WAYS; i++) begin
            key_shadow[i]  = '0;
            pres_shadow[i] = '0;
        end

        // Directed part: empty reads at both extremes of the address space
        push_item(make_req(MODE_READ, '0, '0, 5'd0, 10'd0, 2'd0), 22, 22, 1'b0, 1'b0);
        push_item(make_req(MODE_READ, '1, '1, 5'd31, 10'd1023, 2'd3), 22, 22, 1'b0, 1'b0);
        // new entry with the all-zero key, then a reverse hit on it from the all-ones key
        push_item(make_req(MODE_INSERT, '0, '1, 5'd0, 10'd0, 2'd0), 22, 22, 1'b0, 1'b0);
        push_item(make_req(MODE_INSERT, '1, '0, 5'd31, 10'd0, 2'd0), 22, 22, 1'b0, 1'b0);
        // forward hit on the same key
        push_item(make_req(MODE_INSERT, '0, '1, 5'd17, 10'd0, 2'd0), 22, 22, 1'b0, 1'b0);
        // fill bucket 5, then overflow it
        for (int i = 1; i <= NUM_WAYS + 1; i++) begin
            key = (KEY_W'(i) << 10) | KEY_W'(5);
            push_item(make_req(MODE_INSERT, key, rev_comp(key), 5'(i), 10'd0, 2'd0),
                      22, 22, 1'b0, 1'b0);
        end
        push_item(make_req(MODE_READ, '0, '0, 5'd0, 10'd5, 2'd0), 22, 22, 1'b0, 1'b0);
        push_item(make_req(MODE_READ, '0, '0, 5'd0, 10'd5, 2'd3), 22, 22, 1'b0, 1'b0);
        push_item(make_req(MODE_READ, '0, '0, 5'd0, 10'd0, 2'd0), 22, 22, 1'b0, 1'b0);
        push_item(make_req(MODE_READ, '0, '0, 5'd0, 10'd0, 2'd1), 22, 22, 1'b0, 1'b0);
        // unused mode: no response expected
        push_item(make_req(MODE_NONE, '1, '1, 5'd31, 10'd1023, 2'd3), 22, 22, 1'b0, 1'b0);
        // clear, then check the table is empty and usable again
        push_item(make_req(MODE_CLEAR, '0, '0, 5'd0, 10'd0, 2'd0), 22, 22, 1'b0, 1'b0);
        push_item(make_req(MODE_READ, '0, '0, 5'd0, 10'd5, 2'd0), 22, 22, 1'b0, 1'b0);
        push_item(make_req(MODE_INSERT, KEY_W'(5), '1, 5'd3, 10'd0, 2'd0), 22, 22, 1'b0, 1'b0);
        push_item(make_req(MODE_READ, '0, '0, 5'd0, 10'd5, 2'd0), 22, 22, 1'b0, 1'b0);

        // Random part: four flow-control phases
        send_pct = '{0, 79, 0, 22};
        recv_pct = '{0, 0, 79, 22};
        for (int i = 0; i < HOT_N; i++) hot_bkt[i] = 10'($urandom);
        for (int ph = 0; ph < 4; ph++) begin
            count = 0;
            first = 1'b1;
            while (count < PHASE_ITEMS) begin
                roll = $urandom_range(0, 999);
                r = make_req(MODE_INSERT, rand_key(), rand_key(), 5'($urandom),
                             10'($urandom), 2'($urandom));
                if (roll < 6) begin
                    r.mode = MODE_CLEAR;
                    for (int i = 0; i < HOT_N; i++) hot_bkt[i] = 10'($urandom);
                end else if (roll < 56) begin
                    // noise: anything the fields allow, including the unused mode
                    r.mode = 2'($urandom);
                end else if (roll < 356) begin
                    r.mode = MODE_READ;
                    if (seen_keys.size() != 0 && $urandom_range(0, 3) != 0)
                        r.bucket = seen_keys[$urandom_range(0, seen_keys.size()-1)][9:0];
                end else begin
                    sub = $urandom_range(0, 99);
                    if (sub < 35 && seen_keys.size() != 0) begin
                        // revisit a known k-mer: forward hit when it was kept
                        key = seen_keys[$urandom_range(0, seen_keys.size()-1)];
                        rc  = rev_comp(key);
                    end else if (sub < 60 && seen_keys.size() != 0) begin
                        // offer the reverse strand of a known k-mer: reverse hit
                        rc  = seen_keys[$urandom_range(0, seen_keys.size()-1)];
                        key = rev_comp(rc);
                    end else begin
                        key = rand_key();
                        if ($urandom_range(0, 1) != 0) key[9:0] = hot_bkt[$urandom_range(0, HOT_N-1)];
                        rc = ($urandom_range(0, 3) == 0) ? rand_key() : rev_comp(key);
                    end
                    r.kmer_value = key;
                    r.rc_value   = rc;
                    seen_keys.insert(seen_keys.size(), key);
                    if (seen_keys.size() > 256) void'(seen_keys.pop_front());
                end
                // open each phase with a drain; phases 0 and 3 also hold off the receiver
                push_item(r, send_pct[ph], recv_pct[ph], first, first && (ph == 0 || ph == 3));
                first = 1'b0;
                if (r.mode != MODE_NONE) count++;
            end
        end

        // Hold reset, then release it at a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (req_backlog_q.size() != 0 || n_launched != n_accepted) @(posedge i_clk);
        while (rsp_due_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
